// File: hdl/wide_quotient_round_divider_unit_defines.svh
// Assertion macros shared by the divider checker.
`ifndef WIDE_QUOTIENT_ROUND_DIVIDER_UNIT_DEFINES_SVH
`define WIDE_QUOTIENT_ROUND_DIVIDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WQRD_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("divider assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WQRD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("divider assertion failed");

`endif

// File: hdl/wqrd_pkg.sv
// Shared types, constants and stream layout of the pipelined divider.
`timescale 1ns / 1ps
package wqrd_pkg;

	// Default sizes of the datapath.
	localparam int OPERAND_WIDTH_DEF = 67;
	localparam int QUOT_FRAC_DEF     = 63;

	// Fixed field widths.
	localparam int EXP_IN_W   = 16;
	localparam int SIG_HI_W   = 3;
	localparam int SIG_LO_W   = 64;
	localparam int SIG_IN_W   = SIG_HI_W + SIG_LO_W;
	localparam int EXP_W      = 18;
	localparam int SIG_W      = 64;

	// Input word layout, lowest bit first.
	localparam int IN_NSIGN_LSB = 0;
	localparam int IN_NEXP_LSB  = 1;
	localparam int IN_NHI_LSB   = 17;
	localparam int IN_NLO_LSB   = 20;
	localparam int IN_DSIGN_LSB = 84;
	localparam int IN_DEXP_LSB  = 85;
	localparam int IN_DHI_LSB   = 101;
	localparam int IN_DLO_LSB   = 104;
	localparam int IN_MODE_LSB  = 168;
	localparam int IN_TDATA_W   = 176;

	// Output word layout, lowest bit first.
	localparam int OUT_SIGN_LSB = 0;
	localparam int OUT_EXP_LSB  = 1;
	localparam int OUT_SIG_LSB  = 19;
	localparam int OUT_RUP_LSB  = 83;
	localparam int OUT_PAD_W    = 4;
	localparam int OUT_TDATA_W  = 88;
	localparam int OUT_TUSER_W  = 2;

	// Result class codes.
	typedef enum logic [1:0] {
		CLS_FINITE = 2'd0,
		CLS_ZERO   = 2'd1,
		CLS_INF    = 2'd2
	} class_e;

	// Rounding modes.
	typedef enum logic [1:0] {
		RND_NEAREST_EVEN = 2'd0,
		RND_DOWN         = 2'd1,
		RND_UP           = 2'd2,
		RND_ZERO         = 2'd3
	} rnd_mode_e;

	// Side information that travels with every word through the pipeline.
	typedef struct packed {
		class_e               cls;
		logic                 sign;
		rnd_mode_e            mode;
		logic [EXP_W-1:0]     expo;
	} meta_t;

	// Finished result handed to the output buffer.
	typedef struct packed {
		class_e               cls;
		logic                 sign;
		logic [EXP_W-1:0]     expo;
		logic [SIG_W-1:0]     sig;
		logic                 rounded_up;
	} res_t;

endpackage

// File: hdl/wqrd_norm_stage.sv
// One step of the binary normalizing shift for numerator and denominator.
`timescale 1ns / 1ps
module wqrd_norm_stage #(
	parameter int W     = wqrd_pkg::OPERAND_WIDTH_DEF,
	parameter int CNT_W = 7,
	parameter int SHIFT = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  wqrd_pkg::meta_t      in_meta,
	input  logic [W-1:0]         in_num,
	input  logic [W-1:0]         in_den,
	input  logic [CNT_W-1:0]     in_lzn,
	input  logic [CNT_W-1:0]     in_lzd,
	output logic                 out_valid,
	output wqrd_pkg::meta_t      out_meta,
	output logic [W-1:0]         out_num,
	output logic [W-1:0]         out_den,
	output logic [CNT_W-1:0]     out_lzn,
	output logic [CNT_W-1:0]     out_lzd
);
	import wqrd_pkg::*;

	logic             num_top_zero;
	logic             den_top_zero;
	logic [W-1:0]     num_nx;
	logic [W-1:0]     den_nx;
	logic [CNT_W-1:0] lzn_nx;
	logic [CNT_W-1:0] lzd_nx;
	logic             valid_s1;
	meta_t            meta_s1;
	logic [W-1:0]     num_s1;
	logic [W-1:0]     den_s1;
	logic [CNT_W-1:0] lzn_s1;
	logic [CNT_W-1:0] lzd_s1;

	// Shift left by this step's amount when the top bits are all zero.
	always_comb begin
		num_top_zero = (in_num[W-1 -: SHIFT] == '0);
		den_top_zero = (in_den[W-1 -: SHIFT] == '0);
		num_nx = num_top_zero ? (in_num << SHIFT) : in_num;
		den_nx = den_top_zero ? (in_den << SHIFT) : in_den;
		lzn_nx = in_lzn + (num_top_zero ? CNT_W'(SHIFT) : '0);
		lzd_nx = in_lzd + (den_top_zero ? CNT_W'(SHIFT) : '0);
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= in_meta;
			num_s1  <= num_nx;
			den_s1  <= den_nx;
			lzn_s1  <= lzn_nx;
			lzd_s1  <= lzd_nx;
		end
	end

	assign out_valid = valid_s1;
	assign out_meta  = meta_s1;
	assign out_num   = num_s1;
	assign out_den   = den_s1;
	assign out_lzn   = lzn_s1;
	assign out_lzd   = lzd_s1;

endmodule

// File: hdl/wqrd_div_stage.sv
// One restoring division step: one quotient bit per stage.
`timescale 1ns / 1ps
module wqrd_div_stage #(
	parameter int W   = wqrd_pkg::OPERAND_WIDTH_DEF,
	parameter int Q_W = wqrd_pkg::QUOT_FRAC_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  wqrd_pkg::meta_t  in_meta,
	input  logic [W-1:0]     in_den,
	input  logic [W-1:0]     in_rem,
	input  logic [Q_W-1:0]   in_quo,
	output logic             out_valid,
	output wqrd_pkg::meta_t  out_meta,
	output logic [W-1:0]     out_den,
	output logic [W-1:0]     out_rem,
	output logic [Q_W-1:0]   out_quo
);
	import wqrd_pkg::*;

	logic [W+1:0]   trial;
	logic           fits;
	logic [W-1:0]   rem_nx;
	logic           valid_s1;
	meta_t          meta_s1;
	logic [W-1:0]   den_s1;
	logic [W-1:0]   rem_s1;
	logic [Q_W-1:0] quo_s1;

	// Trial subtract of the divisor from twice the partial remainder.
	always_comb begin
		trial  = {1'b0, in_rem, 1'b0} - {2'b00, in_den};
		fits   = !trial[W+1];
		// The doubled remainder stays below the divisor when it does not fit.
		rem_nx = fits ? trial[W-1:0] : {in_rem[W-2:0], 1'b0};
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= in_meta;
			den_s1  <= in_den;
			rem_s1  <= rem_nx;
			quo_s1  <= {in_quo[Q_W-2:0], fits};
		end
	end

	assign out_valid = valid_s1;
	assign out_meta  = meta_s1;
	assign out_den   = den_s1;
	assign out_rem   = rem_s1;
	assign out_quo   = quo_s1;

endmodule

// File: hdl/wqrd_round.sv
// Rounding decision, increment with carry and result assembly, two stages.
`timescale 1ns / 1ps
module wqrd_round #(
	parameter int W   = wqrd_pkg::OPERAND_WIDTH_DEF,
	parameter int Q_W = wqrd_pkg::QUOT_FRAC_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  wqrd_pkg::meta_t  in_meta,
	input  logic [W-1:0]     in_den,
	input  logic [W-1:0]     in_rem,
	input  logic [Q_W-1:0]   in_quo,
	output logic             out_valid,
	output wqrd_pkg::res_t   out_res
);
	import wqrd_pkg::*;

	logic [W+1:0]   half_diff;
	logic           half_gt;
	logic           half_eq;
	logic           rem_nz;
	logic           inc;
	logic [Q_W:0]   quo_plus;
	logic [Q_W-1:0] quo_rnd;
	logic           carry;
	res_t           res_nx;
	logic           valid_s1;
	meta_t          meta_s1;
	logic [Q_W-1:0] quo_s1;
	logic           inc_s1;
	logic           valid_s2;
	res_t           res_s2;

	// Compare twice the remainder with the divisor and pick the increment.
	always_comb begin
		half_diff = {1'b0, in_rem, 1'b0} - {2'b00, in_den};
		half_eq   = (half_diff == '0);
		half_gt   = !half_diff[W+1] && !half_eq;
		rem_nz    = |in_rem;
		case (in_meta.mode)
			RND_NEAREST_EVEN: inc = half_gt || (half_eq && in_quo[0]);
			RND_DOWN:         inc = in_meta.sign && rem_nz;
			RND_UP:           inc = !in_meta.sign && rem_nz;
			RND_ZERO:         inc = 1'b0;
			default:          inc = 1'b0;
		endcase
	end

	// Increment; a carry out leaves only the leading bit and bumps the exponent.
	always_comb begin
		quo_plus = {1'b0, quo_s1} + (Q_W+1)'(1);
		carry    = quo_plus[Q_W];
		if (!inc_s1) begin
			quo_rnd = quo_s1;
		end else if (carry) begin
			quo_rnd = Q_W'(1) << (Q_W - 1);
		end else begin
			quo_rnd = quo_plus[Q_W-1:0];
		end
		res_nx.cls        = meta_s1.cls;
		res_nx.sign       = meta_s1.sign;
		res_nx.expo       = '0;
		res_nx.sig        = '0;
		res_nx.rounded_up = 1'b0;
		// Zero and infinity carry no exponent, significand or rounding flag.
		if (meta_s1.cls == CLS_FINITE) begin
			res_nx.expo       = meta_s1.expo + EXP_W'(inc_s1 && carry);
			res_nx.sig        = SIG_W'(quo_rnd) << (SIG_W - Q_W);
			res_nx.rounded_up = inc_s1;
		end
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Payload of both stages.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= in_meta;
			quo_s1  <= in_quo;
			inc_s1  <= inc;
			res_s2  <= res_nx;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule

// File: hdl/wqrd_skid.sv
// Two-entry output buffer that decouples the pipeline from the consumer.
`timescale 1ns / 1ps
module wqrd_skid #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_data,
	output logic          in_ready,
	output logic          out_valid,
	output logic [DW-1:0] out_data,
	input  logic          out_ready
);
	logic          out_valid_q;
	logic [DW-1:0] out_data_q;
	logic          skid_valid_q;
	logic [DW-1:0] skid_data_q;
	logic          accept;
	logic          out_take;

	// Ready comes straight from a register: the pipeline stalls only when the skid is full.
	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign out_take = !out_valid_q || out_ready;

	// Occupancy of both entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Word storage.
	always_ff @(posedge clk) begin
		if (out_take) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (accept) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: hdl/wide_quotient_round_divider_unit.sv
// Top level of the pipelined rounding divider.
//
// Channel  Dir  Width  Contents
// s_*      in   176    numerator and denominator (sign, exponent, significand), rounding mode
// m_*      out  88+2   sign, exponent, significand, rounded-up flag; result class on tuser
//
// One word is accepted per cycle while the output buffer is not full. Each
// restoring step and each normalizing step has its own stage. Reset clears
// the valid bits only. A stall at the output fills a two-entry buffer; the
// pipeline freezes only while that buffer is full, so no word is dropped or
// repeated.
`timescale 1ns / 1ps
module wide_quotient_round_divider_unit #(
	parameter int OPERAND_WIDTH          = wqrd_pkg::OPERAND_WIDTH_DEF,
	parameter int QUOTIENT_FRACTION_BITS = wqrd_pkg::QUOT_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// numerator_sign, numerator_exponent, numerator_significand_high,
	// numerator_significand_low, denominator_sign, denominator_exponent,
	// denominator_significand_high, denominator_significand_low, rounding_mode, zero pad
	input  logic [wqrd_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// result_sign, result_exponent, result_significand, rounded_up, zero pad
	output logic [wqrd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// result_class
	output logic [wqrd_pkg::OUT_TUSER_W-1:0]     m_tuser
);
	import wqrd_pkg::*;

	localparam int W     = OPERAND_WIDTH;
	localparam int CNT_W = $clog2(W);
	localparam int NSTEP = CNT_W;
	localparam int QF    = QUOTIENT_FRACTION_BITS;
	localparam int Q_W   = QF + 1;
	localparam int BUF_W = OUT_TUSER_W + OUT_TDATA_W;

	logic                en;
	logic [SIG_IN_W-1:0] num_full;
	logic [SIG_IN_W-1:0] den_full;
	logic [EXP_IN_W-1:0] num_exp;
	logic [EXP_IN_W-1:0] den_exp;
	meta_t               meta_in;
	logic [W-1:0]        num_in;
	logic [W-1:0]        den_in;

	logic                valid_s1;
	meta_t               meta_s1;
	logic [W-1:0]        num_s1;
	logic [W-1:0]        den_s1;

	logic                norm_valid [0:NSTEP];
	meta_t               norm_meta  [0:NSTEP];
	logic [W-1:0]        norm_num   [0:NSTEP];
	logic [W-1:0]        norm_den   [0:NSTEP];
	logic [CNT_W-1:0]    norm_lzn   [0:NSTEP];
	logic [CNT_W-1:0]    norm_lzd   [0:NSTEP];

	logic [W:0]          diff_one;
	logic [W:0]          diff_two;
	logic                ratio_lt;
	meta_t               meta_set;
	logic [W-1:0]        rem_set;

	logic                valid_s2;
	meta_t               meta_s2;
	logic [W-1:0]        den_s2;
	logic [W-1:0]        rem_s2;

	logic                div_valid [0:QF];
	meta_t               div_meta  [0:QF];
	logic [W-1:0]        div_den   [0:QF];
	logic [W-1:0]        div_rem   [0:QF];
	logic [Q_W-1:0]      div_quo   [0:QF];

	logic                res_valid;
	res_t                res;
	logic [BUF_W-1:0]    buf_in;
	logic [BUF_W-1:0]    buf_out;

	// Unpack the input word, trim significands and classify special operands.
	always_comb begin
		num_full = {s_tdata[IN_NHI_LSB +: SIG_HI_W], s_tdata[IN_NLO_LSB +: SIG_LO_W]};
		den_full = {s_tdata[IN_DHI_LSB +: SIG_HI_W], s_tdata[IN_DLO_LSB +: SIG_LO_W]};
		num_exp  = s_tdata[IN_NEXP_LSB +: EXP_IN_W];
		den_exp  = s_tdata[IN_DEXP_LSB +: EXP_IN_W];
		num_in   = num_full[W-1:0];
		den_in   = den_full[W-1:0];
		meta_in.sign = s_tdata[IN_NSIGN_LSB] ^ s_tdata[IN_DSIGN_LSB];
		meta_in.mode = rnd_mode_e'(s_tdata[IN_MODE_LSB +: 2]);
		meta_in.expo = {{(EXP_W-EXP_IN_W){num_exp[EXP_IN_W-1]}}, num_exp}
			- {{(EXP_W-EXP_IN_W){den_exp[EXP_IN_W-1]}}, den_exp};
		// A zero numerator wins over a zero denominator.
		if (num_in == '0) begin
			meta_in.cls = CLS_ZERO;
		end else if (den_in == '0) begin
			meta_in.cls = CLS_INF;
		end else begin
			meta_in.cls = CLS_FINITE;
		end
	end

	// Capture stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Capture stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_in;
			num_s1  <= num_in;
			den_s1  <= den_in;
		end
	end

	// Normalizing shift: each stage tries one power-of-two shift.
	assign norm_valid[0] = valid_s1;
	assign norm_meta[0]  = meta_s1;
	assign norm_num[0]   = num_s1;
	assign norm_den[0]   = den_s1;
	assign norm_lzn[0]   = '0;
	assign norm_lzd[0]   = '0;

	for (genvar i = 0; i < NSTEP; i++) begin : g_norm
		wqrd_norm_stage #(
			.W     (W),
			.CNT_W (CNT_W),
			.SHIFT (1 << (NSTEP - 1 - i))
		) u_norm (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (norm_valid[i]),
			.in_meta   (norm_meta[i]),
			.in_num    (norm_num[i]),
			.in_den    (norm_den[i]),
			.in_lzn    (norm_lzn[i]),
			.in_lzd    (norm_lzd[i]),
			.out_valid (norm_valid[i+1]),
			.out_meta  (norm_meta[i+1]),
			.out_num   (norm_num[i+1]),
			.out_den   (norm_den[i+1]),
			.out_lzn   (norm_lzn[i+1]),
			.out_lzd   (norm_lzd[i+1])
		);
	end

	// Bring the ratio into [1,2): take the leading one and form the first remainder.
	always_comb begin
		diff_one = {1'b0, norm_num[NSTEP]} - {1'b0, norm_den[NSTEP]};
		diff_two = {norm_num[NSTEP], 1'b0} - {1'b0, norm_den[NSTEP]};
		ratio_lt = diff_one[W];
		rem_set  = ratio_lt ? diff_two[W-1:0] : diff_one[W-1:0];
		meta_set = norm_meta[NSTEP];
		meta_set.expo = norm_meta[NSTEP].expo + EXP_W'(norm_lzd[NSTEP])
			- EXP_W'(norm_lzn[NSTEP]) - EXP_W'(ratio_lt);
	end

	// Setup stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= norm_valid[NSTEP];
		end
	end

	// Setup stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_set;
			den_s2  <= norm_den[NSTEP];
			rem_s2  <= rem_set;
		end
	end

	// Long division, one quotient bit per stage.
	assign div_valid[0] = valid_s2;
	assign div_meta[0]  = meta_s2;
	assign div_den[0]   = den_s2;
	assign div_rem[0]   = rem_s2;
	assign div_quo[0]   = Q_W'(1);

	for (genvar j = 0; j < QF; j++) begin : g_div
		wqrd_div_stage #(
			.W   (W),
			.Q_W (Q_W)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_valid[j]),
			.in_meta   (div_meta[j]),
			.in_den    (div_den[j]),
			.in_rem    (div_rem[j]),
			.in_quo    (div_quo[j]),
			.out_valid (div_valid[j+1]),
			.out_meta  (div_meta[j+1]),
			.out_den   (div_den[j+1]),
			.out_rem   (div_rem[j+1]),
			.out_quo   (div_quo[j+1])
		);
	end

	// Rounding and result assembly.
	wqrd_round #(
		.W   (W),
		.Q_W (Q_W)
	) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid[QF]),
		.in_meta   (div_meta[QF]),
		.in_den    (div_den[QF]),
		.in_rem    (div_rem[QF]),
		.in_quo    (div_quo[QF]),
		.out_valid (res_valid),
		.out_res   (res)
	);

	// Pack the result word for the output buffer.
	assign buf_in = {res.cls, {OUT_PAD_W{1'b0}}, res.rounded_up, res.sig, res.expo, res.sign};

	wqrd_skid #(
		.DW (BUF_W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (buf_in),
		.in_ready  (en),
		.out_valid (m_tvalid),
		.out_data  (buf_out),
		.out_ready (m_tready)
	);

	assign s_tready = en;
	assign m_tdata  = buf_out[OUT_TDATA_W-1:0];
	assign m_tuser  = buf_out[BUF_W-1 -: OUT_TUSER_W];

endmodule

// File: hdl/wqrd_checker.sv
// Port-level checks of the divider, bound to the top level.
`timescale 1ns / 1ps
`include "wide_quotient_round_divider_unit_defines.svh"
module wqrd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [wqrd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input logic [wqrd_pkg::OUT_TUSER_W-1:0]     m_tuser
);
	import wqrd_pkg::*;

	// A word that is offered stays offered until taken.
	`WQRD_ASSERT_NEXT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready), m_tvalid)

	// Input back-pressure only follows an output stall in the previous cycle.
	`WQRD_ASSERT_NOW(a_ready_cause, clk, arst_n, (!s_tready), $past(m_tvalid && !m_tready))

	// Zero and infinity results carry nothing but their sign.
	`WQRD_ASSERT_NOW(a_special_clear, clk, arst_n, (m_tvalid && m_tuser != CLS_FINITE), (m_tdata[OUT_TDATA_W-1:1] == '0))

	// Finite results are normalized.
	`WQRD_ASSERT_NOW(a_finite_norm, clk, arst_n, (m_tvalid && m_tuser == CLS_FINITE), m_tdata[OUT_SIG_LSB + SIG_W - 1])

	// An offered word is never held back while the output register is empty.
	`WQRD_ASSERT_NOW(a_empty_ready, clk, arst_n, (s_tvalid && !m_tvalid), s_tready)

endmodule

bind wide_quotient_round_divider_unit wqrd_checker u_wqrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
